@@ src/dwq_pkg.sv @@
package dwq_pkg;

    localparam int TASK_W = 6;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_ADD_SAFE = 2'd1,
        ACT_WAKE_ALL = 2'd2
    } t_action;

    localparam logic signed [1:0] DELTA_PLUS  = 2'sd1;
    localparam logic signed [1:0] DELTA_ZERO  = 2'sd0;
    localparam logic signed [1:0] DELTA_MINUS = -2'sd1;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

@@ src/dedup_wake_queue.sv @@
// Deduplicating wake queue: a FIFO of task numbers that refuses duplicates.
// Input channel: i_action and i_task_id are taken at a rising edge where
// start is high and busy is low. Add and add_safe produce one result on the
// cycle after acceptance, and busy stays low, so adds run at one per cycle
// outside a drain. Wake_all raises busy and then emits one woken task per
// cycle in insertion order; the last one carries o_last, and busy drops
// together with it. An empty drain gives one result, in the cycle after acceptance.
// The queue is a row of MAX_TASKS cells; a drain shifts the whole row one
// cell toward the head every cycle, so the drain rate is set by that shift.
// Queued marks are one flip-flop per task number.
// Results: o_strobe marks each result for exactly one cycle; the receiver
// cannot stall, so each result is taken on the edge that ends its cycle.
// Reset (i_rst_n low, synchronous) empties the queue and clears all marks.
// Action code 3 is accepted and ignored; it yields no result.
module dedup_wake_queue
    import dwq_pkg::*;
#(
    parameter int MAX_TASKS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_action,
    input  logic [TASK_W-1:0]       i_task_id,
    output logic                    o_strobe,
    output logic [TASK_W-1:0]       o_task_num,
    output logic                    o_added,
    output logic                    o_woken,
    output logic signed [1:0]       o_ref_delta,
    output logic                    o_last
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam logic [TASK_W:0] MAX_VAL = (TASK_W + 1)'(MAX_TASKS);

    logic [MAX_TASKS-1:0] r_mark;
    logic                 r_drain;
    logic                 r_strobe;
    logic [TASK_W-1:0]    r_task_num;
    logic                 r_added;
    logic                 r_woken;
    logic signed [1:0]    r_ref_delta;
    logic                 r_last;

    logic [MAX_TASKS-1:0] cell_valid;
    logic [IDX_W-1:0]     cell_task [MAX_TASKS];
    t_cell_ctl            cell_ctl;

    logic                 accept;
    logic [IDX_W-1:0]     in_idx;
    logic                 in_range;
    logic                 add_ok;
    t_action              act;

    assign accept   = start && !r_drain;
    assign act      = t_action'(i_action);
    assign in_idx   = i_task_id[IDX_W-1:0];
    assign in_range = {1'b0, i_task_id} < MAX_VAL;
    assign add_ok   = in_range && !r_mark[in_idx];

    assign cell_ctl.shift = r_drain;
    assign cell_ctl.load  = accept && (act == ACT_ADD || act == ACT_ADD_SAFE) && add_ok;

    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        logic             prev_valid;
        logic             next_valid;
        logic [IDX_W-1:0] next_task;

        if (i == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_mid
            assign prev_valid = cell_valid[i-1];
        end

        if (i == MAX_TASKS - 1) begin : g_end
            assign next_valid = 1'b0;
            assign next_task  = '0;
        end else begin : g_inner
            assign next_valid = cell_valid[i+1];
            assign next_task  = cell_task[i+1];
        end

        dwq_cell #(
            .IDX_W(IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_task      (in_idx),
            .i_prev_valid(prev_valid),
            .i_next_valid(next_valid),
            .i_next_task (next_task),
            .o_valid     (cell_valid[i]),
            .o_task      (cell_task[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark   <= '0;
            r_drain  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (r_drain) begin
                r_mark[cell_task[0]] <= 1'b0;
                r_strobe             <= 1'b1;
                r_task_num           <= TASK_W'(cell_task[0]);
                r_added              <= 1'b0;
                r_woken              <= 1'b1;
                r_ref_delta          <= DELTA_MINUS;
                r_last               <= !cell_valid[1];
                r_drain              <= cell_valid[1];
            end else if (accept) begin
                unique case (act)
                    ACT_ADD, ACT_ADD_SAFE: begin
                        if (add_ok) begin
                            r_mark[in_idx] <= 1'b1;
                        end
                        r_strobe   <= 1'b1;
                        r_task_num <= i_task_id;
                        r_added    <= add_ok;
                        r_woken    <= 1'b0;
                        r_last     <= 1'b1;
                        if (act == ACT_ADD) begin
                            r_ref_delta <= add_ok ? DELTA_PLUS : DELTA_ZERO;
                        end else begin
                            r_ref_delta <= add_ok ? DELTA_ZERO : DELTA_MINUS;
                        end
                    end
                    ACT_WAKE_ALL: begin
                        if (cell_valid[0]) begin
                            r_drain <= 1'b1;
                        end else begin
                            r_strobe    <= 1'b1;
                            r_task_num  <= '0;
                            r_added     <= 1'b0;
                            r_woken     <= 1'b0;
                            r_ref_delta <= DELTA_ZERO;
                            r_last      <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign busy        = r_drain;
    assign o_strobe    = r_strobe;
    assign o_task_num  = r_task_num;
    assign o_added     = r_added;
    assign o_woken     = r_woken;
    assign o_ref_delta = r_ref_delta;
    assign o_last      = r_last;

    a_drain_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> cell_valid[0])
        else $error("drain active with empty head cell");

    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("gap in cell row");

    a_mark_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_mark) == $countones(cell_valid))
        else $error("queued marks disagree with cell row");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_woken && o_last |-> !busy && !cell_valid[0])
        else $error("queue not empty after final woken item");

endmodule

@@ src/dwq_cell.sv @@
module dwq_cell
    import dwq_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_task,
    input  logic             i_prev_valid,
    input  logic             i_next_valid,
    input  logic [IDX_W-1:0] i_next_task,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_task
);

    logic             r_valid;
    logic [IDX_W-1:0] r_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.load && !r_valid && i_prev_valid) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_task <= i_next_task;
        end else if (i_ctl.load && !r_valid && i_prev_valid) begin
            r_task <= i_task;
        end
    end

    assign o_valid = r_valid;
    assign o_task  = r_task;

endmodule

@@ tb/tb_dedup_wake_queue.sv @@
module tb_dedup_wake_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import dwq_pkg::*;

    localparam int         N_TASKS     = 64;
    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int         ITEM_GOAL   = 250;
    localparam int         DRAIN_TAIL  = N_TASKS + 8;
    localparam int         SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [TASK_W-1:0] task_num;
        logic              added;
        logic              woken;
        logic signed [1:0] delta;
        logic              last;
    } t_wake_result;

    typedef struct {
        logic [1:0]        act;
        logic [TASK_W-1:0] id;
        bit                typed;
        t_wake_result      res;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_action;
    logic [TASK_W-1:0] i_task_id;
    logic              o_strobe;
    logic [TASK_W-1:0] o_task_num;
    logic              o_added;
    logic              o_woken;
    logic signed [1:0] o_ref_delta;
    logic              o_last;

    bit                row_typed;
    t_wake_result      row_res;

    bit                task_marked [N_TASKS];
    logic [TASK_W-1:0] task_next [N_TASKS];
    int                q_head;
    int                q_tail;
    bit                q_is_empty;

    t_wake_result      results_due [$];
    int                mismatch_count;
    int                items_sent;
    bit                steady;

    dedup_wake_queue #(
        .MAX_TASKS(N_TASKS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_action   (i_action),
        .i_task_id  (i_task_id),
        .o_strobe   (o_strobe),
        .o_task_num (o_task_num),
        .o_added    (o_added),
        .o_woken    (o_woken),
        .o_ref_delta(o_ref_delta),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_wake_result mk_result(logic [TASK_W-1:0] tn, logic add, logic wok,
                                               logic signed [1:0] dl, logic lst);
        t_wake_result r;
        r.task_num = tn;
        r.added    = add;
        r.woken    = wok;
        r.delta    = dl;
        r.last     = lst;
        return r;
    endfunction

    function automatic t_stim_row drow(logic [1:0] act, logic [TASK_W-1:0] id, bit typed,
                                       logic [TASK_W-1:0] tn = '0, logic add = 1'b0,
                                       logic wok = 1'b0, logic signed [1:0] dl = DELTA_ZERO,
                                       logic lst = 1'b1);
        t_stim_row row;
        row.act   = act;
        row.id    = id;
        row.typed = typed;
        row.res   = mk_result(tn, add, wok, dl, lst);
        return row;
    endfunction

    function automatic void queue_reset();
        foreach (task_marked[k]) begin
            task_marked[k] = 1'b0;
            task_next[k]   = '0;
        end
        q_head     = 0;
        q_tail     = 0;
        q_is_empty = 1'b1;
    endfunction

    function automatic void queue_step(logic [1:0] act, logic [TASK_W-1:0] id, bit typed,
                                       t_wake_result typed_res);
        t_wake_result r;
        bit           fits;
        bit           at_tail;
        int           n;
        int           cur;
        int           nxt;
        case (act)
            ACT_ADD, ACT_ADD_SAFE: begin
                fits = (int'(id) < N_TASKS) && !task_marked[id];
                if (fits) begin
                    task_marked[id] = 1'b1;
                    if (q_is_empty) begin
                        q_head     = int'(id);
                        q_is_empty = 1'b0;
                    end else begin
                        task_next[q_tail] = id;
                    end
                    q_tail = int'(id);
                end
                if (act == ACT_ADD) begin
                    r = mk_result(id, fits, 1'b0, fits ? DELTA_PLUS : DELTA_ZERO, 1'b1);
                end else begin
                    r = mk_result(id, fits, 1'b0, fits ? DELTA_ZERO : DELTA_MINUS, 1'b1);
                end
                results_due.push_back(typed ? typed_res : r);
            end
            ACT_WAKE_ALL: begin
                if (q_is_empty) begin
                    r = mk_result('0, 1'b0, 1'b0, DELTA_ZERO, 1'b1);
                    results_due.push_back(typed ? typed_res : r);
                end else begin
                    n   = 0;
                    cur = q_head;
                    forever begin
                        at_tail          = (cur == q_tail) || (n == N_TASKS - 1);
                        nxt              = int'(task_next[cur]) % N_TASKS;
                        task_marked[cur] = 1'b0;
                        r = mk_result(TASK_W'(cur), 1'b0, 1'b1, DELTA_MINUS, at_tail);
                        results_due.push_back(r);
                        n++;
                        if (at_tail) break;
                        cur = nxt;
                    end
                    q_is_empty = 1'b1;
                    q_head     = 0;
                    q_tail     = 0;
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_wake_result got;
        t_wake_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                got = mk_result(o_task_num, o_added, o_woken, o_ref_delta, o_last);
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT) begin
                        $display("unexpected result: task %0d added %0b woken %0b",
                                 got.task_num, got.added, got.woken,
                                 " delta %0d last %0b", $signed(got.delta), got.last);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_LIMIT) begin
                            $display("mismatch at %0t: expected task %0d added %0b woken %0b",
                                     $realtime, want.task_num, want.added, want.woken,
                                     " delta %0d last %0b,", $signed(want.delta), want.last,
                                     " got task %0d added %0b woken %0b",
                                     got.task_num, got.added, got.woken,
                                     " delta %0d last %0b", $signed(got.delta), got.last);
                        end
                    end
                end
            end
            if (start && !busy) queue_step(i_action, i_task_id, row_typed, row_res);
        end
    end

    function automatic int pick_gap();
        if (steady) return 0;
        if ($urandom_range(0, 11) == 0) return $urandom_range(8, 30);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // Enter and leave on a falling edge; hold the item until accepted.
    task automatic send_item(logic [1:0] act, logic [TASK_W-1:0] id, bit typed = 1'b0,
                             t_wake_result res = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_action  <= act;
        i_task_id <= id;
        row_typed <= typed;
        row_res   <= res;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (act != ACT_IGNORED) items_sent++;
    endtask

    task automatic random_run();
        int                len;
        int                base;
        int                pick;
        bit                narrow;
        logic [1:0]        act;
        logic [TASK_W-1:0] id;
        steady = ($urandom_range(0, 3) == 0);
        len    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 8);
        narrow = ($urandom_range(0, 1) == 1);
        base   = $urandom_range(0, N_TASKS - 8);
        repeat (len) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                act = ACT_IGNORED;
            end else if (pick <= 2) begin
                act = ACT_WAKE_ALL;
            end else begin
                act = $urandom_range(0, 1) ? ACT_ADD : ACT_ADD_SAFE;
            end
            id = narrow ? TASK_W'(base + $urandom_range(0, 7)) : TASK_W'($urandom_range(0, 63));
            send_item(act, id);
        end
        send_item(ACT_WAKE_ALL, TASK_W'($urandom_range(0, 63)));
    endtask

    initial begin : stimulus
        t_stim_row plan [$];
        int        order [$];
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_action       = ACT_ADD;
        i_task_id      = '0;
        row_typed      = 1'b0;
        row_res        = '0;
        mismatch_count = 0;
        items_sent     = 0;
        steady         = 1'b0;
        queue_reset();

        plan = '{
            drow(ACT_WAKE_ALL, 6'd37, 1'b1, 6'd0, 1'b0, 1'b0, DELTA_ZERO, 1'b1),
            drow(ACT_ADD, 6'd0, 1'b1, 6'd0, 1'b1, 1'b0, DELTA_PLUS, 1'b1),
            drow(ACT_ADD, 6'd63, 1'b1, 6'd63, 1'b1, 1'b0, DELTA_PLUS, 1'b1),
            drow(ACT_ADD, 6'd0, 1'b1, 6'd0, 1'b0, 1'b0, DELTA_ZERO, 1'b1),
            drow(ACT_ADD_SAFE, 6'd63, 1'b1, 6'd63, 1'b0, 1'b0, DELTA_MINUS, 1'b1),
            drow(ACT_ADD_SAFE, 6'd42, 1'b1, 6'd42, 1'b1, 1'b0, DELTA_ZERO, 1'b1),
            drow(ACT_IGNORED, 6'd21, 1'b0),
            drow(ACT_ADD, 6'd21, 1'b0),
            drow(ACT_ADD_SAFE, 6'd21, 1'b0),
            drow(ACT_WAKE_ALL, 6'd63, 1'b0),
            drow(ACT_WAKE_ALL, 6'd0, 1'b1, 6'd0, 1'b0, 1'b0, DELTA_ZERO, 1'b1),
            drow(ACT_ADD_SAFE, 6'd63, 1'b1, 6'd63, 1'b1, 1'b0, DELTA_ZERO, 1'b1),
            drow(ACT_ADD, 6'd63, 1'b0),
            drow(ACT_WAKE_ALL, 6'd0, 1'b0),
            drow(ACT_ADD, 6'd21, 1'b0),
            drow(ACT_ADD, 6'd42, 1'b0),
            drow(ACT_IGNORED, 6'd0, 1'b0),
            drow(ACT_ADD_SAFE, 6'd0, 1'b0),
            drow(ACT_ADD, 6'd42, 1'b0),
            drow(ACT_WAKE_ALL, 6'd21, 1'b0),
            drow(ACT_ADD, 6'd0, 1'b0)
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) send_item(plan[k].act, plan[k].id, plan[k].typed, plan[k].res);

        // Fill every slot, then drain the full queue.
        for (int k = 0; k < N_TASKS; k++) order.push_back(k);
        order.shuffle();
        steady = 1'b1;
        foreach (order[k]) send_item($urandom_range(0, 1) ? ACT_ADD : ACT_ADD_SAFE,
                                     TASK_W'(order[k]));
        steady = 1'b0;
        send_item(ACT_WAKE_ALL, 6'd0);

        while (items_sent < ITEM_GOAL) random_run();

        start <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("dedup_wake_queue test passed");
        end else begin
            $display("dedup_wake_queue test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("dedup_wake_queue test failed");
        $finish;
    end

endmodule
